[design/ucl_pkg.sv]
// Shared types, codes and keyword tables for the UART command line controller.
`timescale 1ns / 1ps
package ucl_pkg;

  localparam int unsigned NKEY    = 6;
  localparam int unsigned KEY_PWM = 5;

  // Command codes held between the line parser and the mode logic.
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_READ    = 4'd1,
    CMD_LEDON   = 4'd2,
    CMD_LEDOFF  = 4'd3,
    CMD_PWM     = 4'd4,
    CMD_LOGON   = 4'd5,
    CMD_LOGOFF  = 4'd6,
    CMD_UNKNOWN = 4'd7,
    CMD_PWMERR  = 4'd8
  } cmd_e;

  // Status codes reported with each result.
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_OK       = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_DEBUG    = 3'd5,
    ST_AUTO     = 3'd6
  } status_e;

  // Number parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_BLANK = 3'b001,
    PH_DIGIT = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  // Outcome of one received byte as seen by the line parser.
  typedef struct packed {
    logic       fin;
    logic       ovf;
    cmd_e       cmd;
    logic [6:0] duty;
  } line_res_t;

  // Effect of one command on the controller state.
  typedef struct packed {
    status_e status;
    logic    req;
    logic    led_we;
    logic    led_val;
    logic    log_we;
    logic    log_val;
    logic    pwm_we;
  } exec_t;

  // Keyword text in upper case, padded with NUL.
  localparam logic [7:0] KEY_CHAR [NKEY][8] = '{
    '{8'h52, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h4F, 8'h46, 8'h46, 8'h00},
    '{8'h4C, 8'h4F, 8'h47, 8'h20, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h4C, 8'h4F, 8'h47, 8'h20, 8'h4F, 8'h46, 8'h46, 8'h00},
    '{8'h50, 8'h57, 8'h4D, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KEY_LEN [NKEY] = '{3'd4, 3'd6, 3'd7, 3'd6, 3'd7, 3'd4};
  localparam cmd_e KEY_CMD [NKEY] = '{CMD_READ, CMD_LEDON, CMD_LEDOFF,
                                      CMD_LOGON, CMD_LOGOFF, CMD_PWM};

  localparam logic [6:0] DUTY_MAX = 7'd100;
  localparam logic [6:0] DUTY_SAT = 7'd101;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any product up to 131071 * 100.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  // Translate a command into its effect on the controller state.
  function automatic exec_t exec_cmd(cmd_e cmd);
    exec_t e;
    e = '0;
    e.status = ST_NONE;
    unique case (cmd)
      CMD_READ: begin
        e.req = 1'b1;
      end
      CMD_LEDON: begin
        e.led_we = 1'b1; e.led_val = 1'b1; e.status = ST_OK;
      end
      CMD_LEDOFF: begin
        e.led_we = 1'b1; e.led_val = 1'b0; e.status = ST_OK;
      end
      CMD_PWM: begin
        e.pwm_we = 1'b1; e.status = ST_OK;
      end
      CMD_PWMERR: e.status = ST_RANGE;
      CMD_LOGON: begin
        e.log_we = 1'b1; e.log_val = 1'b1; e.status = ST_OK;
      end
      CMD_LOGOFF: begin
        e.log_we = 1'b1; e.log_val = 1'b0; e.status = ST_OK;
      end
      CMD_UNKNOWN: e.status = ST_UNKNOWN;
      default: e.status = ST_NONE;
    endcase
    return e;
  endfunction

endpackage

[design/ucl_line_parser.sv]
// Line gathering, incremental keyword matching and PWM number parsing.
`timescale 1ns / 1ps
module ucl_line_parser import ucl_pkg::*; #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_en_i,
  input  logic [7:0] byte_i,
  output line_res_t res_o
);

  localparam int unsigned LW = $clog2(LINE_BYTES);

  logic [LW-1:0] len_q, len_d;
  logic [5:0]    cand_q, cand_d;
  phase_e        ph_q, ph_d;
  logic          neg_q, neg_d;
  logic [6:0]    val_q, val_d;
  logic          te_q, te_d;

  // Drop candidates that the text of the given length does not match in full.
  function automatic logic [5:0] settle(logic [5:0] cand, logic [LW-1:0] pos);
    logic [5:0] r;
    logic       keep;
    r = cand;
    for (int i = 0; i < NKEY; i++) begin
      if (i == KEY_PWM) keep = (pos >= LW'(4));
      else              keep = (pos == LW'(KEY_LEN[i]));
      if (!keep) r[i] = 1'b0;
    end
    return r;
  endfunction

  logic [7:0]  c;
  logic        is_eol, is_blank, is_digit;
  logic [10:0] val_x10;
  logic [5:0]  cand_s;
  logic        found;
  logic        fin_s, ovf_s;
  cmd_e        cmd_s;
  logic [6:0]  duty_s;

  always_comb begin
    c        = (byte_i >= 8'h61 && byte_i <= 8'h7A) ? byte_i - 8'd32 : byte_i;
    is_eol   = (byte_i == 8'h0D) || (byte_i == 8'h0A);
    is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    val_x10  = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {7'd0, c[3:0]};
  end

  // Classify the finished line: first live keyword in list order wins.
  always_comb begin
    cand_s = te_q ? cand_q : settle(cand_q, len_q);
    found  = 1'b0;
    cmd_s  = CMD_UNKNOWN;
    duty_s = '0;
    for (int i = 0; i < NKEY; i++) begin
      if (cand_s[i] && !found) begin
        found = 1'b1;
        if (i == KEY_PWM) begin
          if ((neg_q && val_q != '0) || val_q > DUTY_MAX) begin
            cmd_s = CMD_PWMERR;
          end else begin
            cmd_s  = CMD_PWM;
            duty_s = val_q;
          end
        end else begin
          cmd_s = KEY_CMD[i];
        end
      end
    end
  end

  // Next line state for one received byte.
  always_comb begin
    len_d  = len_q;
    cand_d = cand_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    val_d  = val_q;
    te_d   = te_q;
    fin_s  = 1'b0;
    ovf_s  = 1'b0;
    if (byte_en_i) begin
      priority if (is_eol) begin
        if (len_q != '0) begin
          fin_s = 1'b1;
          len_d = '0; cand_d = '1; ph_d = PH_BLANK; neg_d = 1'b0; val_d = '0; te_d = 1'b0;
        end
      end else if (len_q < LW'(LINE_BYTES - 1)) begin
        if (!te_q) begin
          if (c == 8'h00) begin
            cand_d = settle(cand_q, len_q);
            te_d   = 1'b1;
          end else begin
            for (int i = 0; i < NKEY; i++) begin
              if (!((len_q < LW'(KEY_LEN[i])) && (KEY_CHAR[i][len_q[2:0]] == c)) &&
                  !((i == KEY_PWM) && (len_q >= LW'(4)))) begin
                cand_d[i] = 1'b0;
              end
            end
            // atoi-style number after the PWM prefix
            if (cand_d[KEY_PWM] && len_q >= LW'(4)) begin
              priority if (ph_q == PH_BLANK && is_blank) begin
                ph_d = PH_BLANK;
              end else if (ph_q == PH_BLANK && c == 8'h2B) begin
                ph_d = PH_DIGIT;
              end else if (ph_q == PH_BLANK && c == 8'h2D) begin
                neg_d = 1'b1;
                ph_d  = PH_DIGIT;
              end else if (ph_q != PH_DONE) begin
                if (is_digit) begin
                  val_d = (val_x10 > 11'(DUTY_MAX)) ? DUTY_SAT : val_x10[6:0];
                  ph_d  = PH_DIGIT;
                end else begin
                  ph_d = PH_DONE;
                end
              end else begin
                ph_d = ph_q;
              end
            end
          end
        end
        len_d = len_q + 1'b1;
      end else begin
        ovf_s = 1'b1;
        len_d = '0; cand_d = '1; ph_d = PH_BLANK; neg_d = 1'b0; val_d = '0; te_d = 1'b0;
      end
    end
  end

  assign res_o = '{fin: fin_s, ovf: ovf_s, cmd: cmd_s, duty: duty_s};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cand_q <= '1;
      ph_q   <= PH_BLANK;
      neg_q  <= 1'b0;
      val_q  <= '0;
      te_q   <= 1'b0;
    end else begin
      len_q  <= len_d;
      cand_q <= cand_d;
      ph_q   <= ph_d;
      neg_q  <= neg_d;
      val_q  <= val_d;
      te_q   <= te_d;
    end
  end

endmodule

[design/ucl_pwm_scale.sv]
// PWM compare register, loaded with period * duty / 100 by reciprocal multiply.
`timescale 1ns / 1ps
module ucl_pwm_scale import ucl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [23:0] product_i,
  output logic [16:0] compare_o
);

  logic [47:0] scaled;
  logic [16:0] compare_q, compare_d;

  // Division by 100 as a multiply by a scaled reciprocal and a shift.
  always_comb begin
    scaled    = {24'd0, product_i} * {24'd0, RECIP_100};
    compare_d = load_i ? scaled[RECIP_SHIFT +: 17] : compare_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_q <= '0;
    end else begin
      compare_q <= compare_d;
    end
  end

  assign compare_o = compare_q;

endmodule

[design/uart_command_line_controller.sv]
// Top level of the UART command line and mode controller.
//
// Input channel (in_valid_i / in_ready_o): func_i selects a received byte
// (rx_byte_i) or a one millisecond tick carrying button_level_i. Each transfer
// yields exactly one result on the output channel (out_valid_o / out_ready_i):
// echo, status, sensor request and a snapshot of LED, PWM compare, mode and
// logging after that item.
// State and the PWM product are latched at acceptance; the compare value is
// rescaled into its register as that item moves into the output register.
// Throughput is one item per cycle; the two-entry pipeline advances whenever
// the output register is empty or being taken, so a stalled receiver holds
// both stages and deasserts in_ready_o until the result is taken.
// Configuration registers (debounce, blink, log period, PWM period) are written
// via cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
// the block is idle; the block does not enforce this. Reset leaves autonomous
// mode, LED off, logging off, compare zero, empty line, registers at defaults.
`timescale 1ns / 1ps
module uart_command_line_controller import ucl_pkg::*; #(
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned TICK_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        echo_valid_o,
  output logic [7:0]  echo_byte_o,
  output logic [2:0]  status_o,
  output logic        sensor_request_o,
  output logic        led_level_o,
  output logic [16:0] pwm_compare_o,
  output logic        debug_mode_o,
  output logic        logging_on_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned CW = (TICK_BITS > 16) ? TICK_BITS : 16;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_BLINK    = 2'd1;
  localparam logic [1:0] REG_LOG      = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;

  // Result fields carried through the pipeline.
  typedef struct packed {
    logic       ev;
    logic [7:0] eb;
    status_e    st;
    logic       req;
    logic       led;
    logic       dbg;
    logic       log;
  } res_t;

  logic [15:0] deb_cfg_q, blink_cfg_q, log_cfg_q;
  logic [16:0] period_q;

  logic       adv, acc;
  logic       s1_v_q, out_v_q;
  res_t       s1_q, s1_d, out_q;
  logic       s1_pwm_q, s1_pwm_d;
  logic [23:0] s1_prod_q, s1_prod_d;

  cmd_e       pend_cmd_q, pend_cmd_d;
  logic [6:0] pend_duty_q, pend_duty_d;
  logic       mode_q, mode_d, led_q, led_d, log_q, log_d;
  logic       last_q, last_d, stable_q, stable_d;
  logic [TICK_BITS-1:0] deb_q, deb_d, blink_q, blink_d, logc_q, logc_d;

  line_res_t  lres;
  exec_t      ex;
  logic [6:0] duty_sel;

  function automatic logic [TICK_BITS-1:0] sat_inc(logic [TICK_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Pipeline control: both stages move together when the output is free.
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  ucl_line_parser #(
    .LINE_BYTES(LINE_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(acc && !func_i),
    .byte_i   (rx_byte_i),
    .res_o    (lres)
  );

  // Mode, timers and command execution for one accepted item.
  always_comb begin
    pend_cmd_d  = pend_cmd_q;
    pend_duty_d = pend_duty_q;
    mode_d      = mode_q;
    led_d       = led_q;
    log_d       = log_q;
    last_d      = last_q;
    stable_d    = stable_q;
    deb_d       = deb_q;
    blink_d     = blink_q;
    logc_d      = logc_q;
    ex          = '0;
    duty_sel    = '0;
    s1_d        = '0;
    s1_d.st     = ST_NONE;
    if (acc) begin
      if (!func_i) begin
        s1_d.ev = 1'b1;
        s1_d.eb = rx_byte_i;
        if (lres.fin) begin
          if (mode_q) begin
            ex       = exec_cmd(lres.cmd);
            duty_sel = lres.duty;
            s1_d.st  = ex.status;
          end else begin
            pend_cmd_d  = lres.cmd;
            pend_duty_d = lres.duty;
          end
        end else if (lres.ovf) begin
          s1_d.st = ST_OVERFLOW;
        end
      end else begin
        blink_d = sat_inc(blink_q);
        logc_d  = sat_inc(logc_q);
        deb_d   = (button_level_i != last_q) ? '0 : sat_inc(deb_q);
        if (CW'(deb_d) > CW'(deb_cfg_q) && button_level_i != stable_q) begin
          stable_d = button_level_i;
          if (!button_level_i) begin
            if (!mode_q) begin
              mode_d  = 1'b1;
              s1_d.st = ST_DEBUG;
              if (pend_cmd_q != CMD_NONE) begin
                ex          = exec_cmd(pend_cmd_q);
                duty_sel    = pend_duty_q;
                pend_cmd_d  = CMD_NONE;
                pend_duty_d = '0;
              end
            end else begin
              mode_d  = 1'b0;
              log_d   = 1'b0;
              s1_d.st = ST_AUTO;
            end
          end
        end
        last_d = button_level_i;
      end
      // Apply the command effect before the periodic checks.
      if (ex.led_we) led_d = ex.led_val;
      if (ex.log_we) log_d = ex.log_val;
      s1_d.req = ex.req;
      if (func_i) begin
        if (!mode_d) begin
          if (CW'(blink_d) >= CW'(blink_cfg_q)) begin
            led_d   = ~led_d;
            blink_d = '0;
          end
        end else if (log_d && CW'(logc_d) >= CW'(log_cfg_q)) begin
          s1_d.req = 1'b1;
          logc_d   = '0;
        end
      end
    end
    s1_d.led  = led_d;
    s1_d.dbg  = mode_d;
    s1_d.log  = log_d;
    s1_pwm_d  = ex.pwm_we;
    s1_prod_d = 24'(period_q) * 24'(duty_sel);
  end

  // Controller state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cmd_q  <= CMD_NONE;
      pend_duty_q <= '0;
      mode_q      <= 1'b0;
      led_q       <= 1'b0;
      log_q       <= 1'b0;
      last_q      <= 1'b1;
      stable_q    <= 1'b1;
      deb_q       <= '0;
      blink_q     <= '0;
      logc_q      <= '0;
    end else begin
      pend_cmd_q  <= pend_cmd_d;
      pend_duty_q <= pend_duty_d;
      mode_q      <= mode_d;
      led_q       <= led_d;
      log_q       <= log_d;
      last_q      <= last_d;
      stable_q    <= stable_d;
      deb_q       <= deb_d;
      blink_q     <= blink_d;
      logc_q      <= logc_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_cfg_q   <= 16'd50;
      blink_cfg_q <= 16'd500;
      log_cfg_q   <= 16'd1000;
      period_q    <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: deb_cfg_q   <= cfg_data_i[15:0];
        REG_BLINK:    blink_cfg_q <= cfg_data_i[15:0];
        REG_LOG:      log_cfg_q   <= cfg_data_i[15:0];
        REG_PERIOD:   period_q    <= cfg_data_i;
        default:      period_q    <= period_q;
      endcase
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= acc;
      out_v_q <= s1_v_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= s1_d;
      s1_pwm_q  <= s1_pwm_d;
      s1_prod_q <= s1_prod_d;
      out_q     <= s1_q;
    end
  end

  ucl_pwm_scale u_pwm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv && s1_v_q && s1_pwm_q),
    .product_i(s1_prod_q),
    .compare_o(pwm_compare_o)
  );

  assign out_valid_o      = out_v_q;
  assign echo_valid_o     = out_q.ev;
  assign echo_byte_o      = out_q.eb;
  assign status_o         = out_q.st;
  assign sensor_request_o = out_q.req;
  assign led_level_o      = out_q.led;
  assign debug_mode_o     = out_q.dbg;
  assign logging_on_o     = out_q.log;

  // Entering debug mode is reported only with debug mode set.
  a_debug_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DEBUG |-> debug_mode_o)
    else $error("entered-debug status without debug mode");

  // Leaving debug mode also turns logging off.
  a_auto_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_AUTO |-> !debug_mode_o && !logging_on_o)
    else $error("autonomous status with debug or logging still on");

  // Logging is only ever enabled in debug mode.
  a_log_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> debug_mode_o || !logging_on_o)
    else $error("logging on in autonomous mode");

  // A tick never carries an echo.
  a_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i |=> ##1 (!out_valid_o || !echo_valid_o ||
      !$past(out_ready_i)))
    else $error("tick result carries an echo");

endmodule

[dv/uart_command_line_controller_tb.sv]
// Self-checking testbench for the UART command line and mode controller.
`timescale 1ns / 1ps
module uart_command_line_controller_tb;
  import ucl_pkg::*;

  localparam int unsigned LINE_LEN = 64;
  localparam int unsigned TMAX     = 65535;
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_BLINK    = 2'd1;
  localparam logic [1:0] REG_LOG      = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;
  localparam logic FN_BYTE = 1'b0;
  localparam logic FN_TICK = 1'b1;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic [2:0]  status;
    logic        req;
    logic        led;
    logic [16:0] compare;
    logic        debug;
    logic        logging;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        button_level_i = 1'b1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        echo_valid_o;
  logic [7:0]  echo_byte_o;
  logic [2:0]  status_o;
  logic        sensor_request_o;
  logic        led_level_o;
  logic [16:0] pwm_compare_o;
  logic        debug_mode_o;
  logic        logging_on_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [16:0] cfg_data_i = 17'd0;

  uart_command_line_controller dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  int unsigned p_debounce, p_blink, p_logper, p_period;
  int unsigned ln_len, num_val, pend_duty;
  logic [5:0]  cands;
  int unsigned num_phase;
  logic        num_neg, txt_end;
  cmd_e        pend_cmd;
  logic        m_debug, m_led, m_log, smp_last, smp_stable;
  logic [16:0] m_cmp;
  int unsigned cnt_deb, cnt_blink, cnt_log;

  result_t expected_q[$];
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;
  int unsigned rx_hold = 0;

  function automatic int unsigned sat_up(int unsigned v);
    return (v >= TMAX) ? TMAX : v + 1;
  endfunction

  function automatic void line_clear();
    ln_len = 0; cands = 6'h3F; num_phase = 0; num_neg = 1'b0; num_val = 0;
    txt_end = 1'b0;
  endfunction

  function automatic void model_reset();
    p_debounce = 50; p_blink = 500; p_logper = 1000; p_period = 65536;
    line_clear();
    pend_cmd = CMD_NONE; pend_duty = 0;
    m_debug = 0; m_led = 0; m_log = 0; m_cmp = '0;
    smp_last = 1; smp_stable = 1; cnt_deb = 0; cnt_blink = 0; cnt_log = 0;
  endfunction

  function automatic void keep_full(int unsigned pos);
    for (int i = 0; i < NKEY; i++) begin
      if (!((i == KEY_PWM) ? (pos >= 4) : (pos == KEY_LEN[i]))) cands[i] = 1'b0;
    end
  endfunction

  function automatic void number_step(logic [7:0] c);
    if (num_phase == 0) begin
      if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) return;
      if (c == "+") begin num_phase = 1; return; end
      if (c == "-") begin num_neg = 1; num_phase = 1; return; end
    end
    if (num_phase <= 1) begin
      if (c >= "0" && c <= "9") begin
        num_val = num_val * 10 + (c - "0");
        if (num_val > 100) num_val = 101;
        num_phase = 1;
      end else begin
        num_phase = 2;
      end
    end
  endfunction

  function automatic void match_char(int unsigned pos, logic [7:0] b);
    logic [7:0] c;
    c = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    if (c == 8'h00) begin
      keep_full(pos); txt_end = 1'b1; return;
    end
    for (int i = 0; i < NKEY; i++) begin
      if (!cands[i]) continue;
      if (pos < KEY_LEN[i] && KEY_CHAR[i][pos] == c) continue;
      if (i == KEY_PWM && pos >= 4) continue;
      cands[i] = 1'b0;
    end
    if (cands[KEY_PWM] && pos >= 4) number_step(c);
  endfunction

  function automatic cmd_e line_command(output int unsigned duty);
    duty = 0;
    if (!txt_end) keep_full(ln_len);
    for (int i = 0; i < NKEY; i++) begin
      if (!cands[i]) continue;
      if (i == KEY_PWM) begin
        if ((num_neg && num_val != 0) || num_val > 100) return CMD_PWMERR;
        duty = num_val;
      end
      return KEY_CMD[i];
    end
    return CMD_UNKNOWN;
  endfunction

  function automatic status_e run_command(cmd_e cmd, int unsigned duty, inout logic req);
    longint unsigned prod;
    case (cmd)
      CMD_READ:    begin req = 1'b1; return ST_NONE; end
      CMD_LEDON:   begin m_led = 1'b1; return ST_OK; end
      CMD_LEDOFF:  begin m_led = 1'b0; return ST_OK; end
      CMD_PWM: begin
        prod = longint'(p_period) * duty / 100;
        m_cmp = prod[16:0];
        return ST_OK;
      end
      CMD_PWMERR:  return ST_RANGE;
      CMD_LOGON:   begin m_log = 1'b1; return ST_OK; end
      CMD_LOGOFF:  begin m_log = 1'b0; return ST_OK; end
      CMD_UNKNOWN: return ST_UNKNOWN;
      default:     return ST_NONE;
    endcase
  endfunction

  // Advance the controller model by one accepted item.
  function automatic result_t controller_step(logic fn, logic [7:0] b, logic lvl);
    result_t r;
    status_e st;
    cmd_e cmd;
    int unsigned duty;
    logic req;
    st = ST_NONE; req = 1'b0; r = '0;
    if (fn == FN_BYTE) begin
      r.echo_valid = 1'b1; r.echo_byte = b;
      if (b == 8'h0D || b == 8'h0A) begin
        if (ln_len > 0) begin
          cmd = line_command(duty);
          if (m_debug) st = run_command(cmd, duty, req);
          else begin pend_cmd = cmd; pend_duty = duty; end
          line_clear();
        end
      end else if (ln_len < LINE_LEN - 1) begin
        if (!txt_end) match_char(ln_len, b);
        ln_len++;
      end else begin
        line_clear(); st = ST_OVERFLOW;
      end
    end else begin
      cnt_blink = sat_up(cnt_blink);
      cnt_log = sat_up(cnt_log);
      cnt_deb = (lvl != smp_last) ? 0 : sat_up(cnt_deb);
      if (cnt_deb > p_debounce && lvl != smp_stable) begin
        smp_stable = lvl;
        if (lvl == 1'b0) begin
          if (!m_debug) begin
            m_debug = 1'b1; st = ST_DEBUG;
            if (pend_cmd != CMD_NONE) begin
              void'(run_command(pend_cmd, pend_duty, req));
              pend_cmd = CMD_NONE; pend_duty = 0;
            end
          end else begin
            m_debug = 1'b0; m_log = 1'b0; st = ST_AUTO;
          end
        end
      end
      smp_last = lvl;
      if (!m_debug) begin
        if (cnt_blink >= p_blink) begin m_led = ~m_led; cnt_blink = 0; end
      end else if (m_log && cnt_log >= p_logper) begin
        req = 1'b1; cnt_log = 0;
      end
    end
    r.status = st; r.req = req; r.led = m_led; r.compare = m_cmp;
    r.debug = m_debug; r.logging = m_log;
    return r;
  endfunction

  // Offer one item at a falling edge, after random idling if tx_idle_en is set, and
  // hold it until the transfer happens. Valid stays high after the transfer until
  // the next falling edge, where the next call replaces it or withdraws it to idle.
  task automatic send_item(logic fn, logic [7:0] b, logic lvl);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; func_i <= fn; rx_byte_i <= b; button_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(controller_step(fn, b, lvl));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(FN_BYTE, s[i], 1'b1);
    send_item(FN_BYTE, 8'h0D, 1'b1);
  endtask

  task automatic send_ticks(int unsigned n, logic lvl);
    repeat (n) send_item(FN_TICK, 8'($urandom), lvl);
  endtask

  // Hold the button down long enough to be taken, then release it.
  task automatic press_button();
    send_ticks(p_debounce + 2, 1'b0);
    send_ticks(p_debounce + 2, 1'b1);
  endtask

  // Withdraw the input and wait until every expected result has arrived.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[16:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_DEBOUNCE: p_debounce = val & 16'hFFFF;
      REG_BLINK:    p_blink = val & 16'hFFFF;
      REG_LOG:      p_logper = val & 16'hFFFF;
      default:      p_period = val & 17'h1FFFF;
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready_i <= !(rx_idle_en && $urandom_range(99) < 37);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {echo_valid_o, echo_byte_o, status_o, sensor_request_o, led_level_o,
             pwm_compare_o, debug_mode_o, logging_on_o};
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  task automatic test_commands_in_debug();
    write_reg(REG_DEBOUNCE, 0);
    write_reg(REG_BLINK, 1);
    write_reg(REG_LOG, 1);
    write_reg(REG_PERIOD, 65536);
    send_text("led on");
    press_button();
    send_text("READ"); send_text("LED OFF"); send_text("Log On");
    send_ticks(3, 1'b1);
    send_text("log off"); send_text("PWM 100"); send_text("pwm \t-0");
    send_text("PWM +55"); send_text("PWM 101"); send_text("PWM -3");
    send_text("PWM 99999"); send_text("PWM"); send_text("bogus");
    send_item(FN_BYTE, 8'h0A, 1'b1);
    send_item(FN_BYTE, 8'hFF, 1'b1);
    send_item(FN_BYTE, 8'h00, 1'b1);
    send_text("READ");
    drain();
  endtask

  task automatic test_null_and_overflow();
    send_item(FN_BYTE, "r", 1'b1); send_item(FN_BYTE, "e", 1'b1);
    send_item(FN_BYTE, "a", 1'b1); send_item(FN_BYTE, "d", 1'b1);
    send_item(FN_BYTE, 8'h00, 1'b1); send_item(FN_BYTE, "x", 1'b1);
    send_item(FN_BYTE, 8'h0D, 1'b1);
    repeat (70) send_item(FN_BYTE, 8'h41, 1'b1);
    send_item(FN_BYTE, 8'h0D, 1'b1);
  endtask

  task automatic test_back_pressure();
    rx_hold = 60;
    repeat (20) send_item(FN_BYTE, 8'($urandom_range(32, 126)), 1'b1);
    send_item(FN_BYTE, 8'h0D, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(int unsigned n);
    string cmds[8] = '{"READ", "LED ON", "LED OFF", "LOG ON", "LOG OFF",
                       "PWM ", "PWM -", "XYZ"};
    string s;
    int unsigned k;
    // A stretch of back-to-back transfers with neither side idling.
    tx_idle_en = 1'b0; rx_idle_en = 1'b0;
    repeat (40) send_item(FN_BYTE, 8'($urandom), 1'b1);
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    k = 40;
    while (k < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          s = cmds[$urandom_range(7)];
          if (s.substr(0, 2) == "PWM")
            s = {s, $sformatf("%0d", $urandom_range(120))};
          if ($urandom_range(1)) s = s.tolower();
          send_text(s);
          k += s.len() + 1;
        end
        4, 5: begin
          send_ticks(5, 1'($urandom_range(1))); k += 5;
        end
        6: begin
          press_button(); k += 2 * (p_debounce + 2);
        end
        7: begin
          if ($urandom_range(3) == 0) begin
            drain();
            tx_idle_en = 1'b0; rx_idle_en = 1'b0;
          end else begin
            tx_idle_en = 1'b1; rx_idle_en = 1'b1;
          end
        end
        default: begin
          send_item(FN_BYTE, 8'($urandom), 1'b1); k++;
        end
      endcase
    end
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_DEBOUNCE, 65535);
    write_reg(REG_BLINK, 65535);
    write_reg(REG_LOG, 65535);
    write_reg(REG_PERIOD, 1);
    send_text("pwm 100");
    send_ticks(4, 1'b0);
    drain();
    write_reg(REG_DEBOUNCE, 1);
    write_reg(REG_BLINK, 3);
    write_reg(REG_LOG, 2);
    write_reg(REG_PERIOD, 12345);
    send_ticks(3, 1'b1);
    press_button();
    send_text("log on"); send_text("pwm 37");
    send_ticks(10, 1'b1);
    drain();
  endtask

  initial begin
    model_reset();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_commands_in_debug();
    test_null_and_overflow();
    test_back_pressure();
    write_reg(REG_DEBOUNCE, 2);
    write_reg(REG_BLINK, 7);
    write_reg(REG_LOG, 5);
    write_reg(REG_PERIOD, 1000);
    test_random_traffic(490);
    test_settings();
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

[uart_command_line_controller.f]
design/ucl_pkg.sv
design/ucl_line_parser.sv
design/ucl_pwm_scale.sv
design/uart_command_line_controller.sv
dv/uart_command_line_controller_tb.sv
